// ===== hw/rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the source text tokenizer: token kinds,
// token records, per-byte record bundles and configuration register indexes.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Most records one input byte can produce (close + single + end)
  localparam int unsigned MaxRecs = 3;

  // Configuration register indexes
  localparam logic [1:0] CfgKeepWhitespace = 2'd0;
  localparam logic [1:0] CfgKeepComments   = 2'd1;

  typedef enum logic [2:0] {
    KindSpace   = 3'd0,
    KindComment = 3'd1,
    KindString  = 3'd2,
    KindWord    = 3'd3,
    KindPunct   = 3'd4,
    KindError   = 3'd5,
    KindEnd     = 3'd6
  } token_kind_e;

  // One token record as it leaves the block
  typedef struct packed {
    token_kind_e kind;
    logic [31:0] start;
    logic [31:0] len;
    logic [31:0] line;
    logic [31:0] col;
  } record_t;

  // All records caused by one input item, count is never zero in the queue
  typedef struct packed {
    logic [1:0]                 count;
    record_t [MaxRecs-1:0]      rec;
  } bundle_t;

  // Configuration flags seen by the front end
  typedef struct packed {
    logic keep_whitespace;
    logic keep_comments;
  } cfg_t;

endpackage

// ===== hw/rtl/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front
// Scanner front end: accepts one byte item per cycle while the record
// queue is not full, runs the scan mode machine and the position counters,
// and pushes the item's token records as one bundle into the record queue.
// ----------------------------------------------------------------------------
module stt_front #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         byte_value_i,
  input  logic               has_byte_i,
  input  logic               end_of_source_i,
  input  stt_pkg::cfg_t      cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output stt_pkg::bundle_t   bundle_o
);

  localparam int unsigned Pb     = POSITION_BITS;
  localparam int unsigned LcBits = (POSITION_BITS < 32) ? POSITION_BITS : 32;

  // Scan modes
  localparam logic [2:0] ModeIdle    = 3'd0;
  localparam logic [2:0] ModeSpace   = 3'd1;
  localparam logic [2:0] ModeSlash   = 3'd2;
  localparam logic [2:0] ModeComment = 3'd3;
  localparam logic [2:0] ModeString  = 3'd4;
  localparam logic [2:0] ModeEscape  = 3'd5;
  localparam logic [2:0] ModeWord    = 3'd6;

  // Byte codes
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChUnder   = 8'h5F;
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChSemi    = 8'h3B;

  typedef struct packed {
    logic             en;
    stt_pkg::record_t rec;
  } close_t;

  function automatic logic is_space(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == ChNewline || b == 8'h0B ||
           b == 8'h0C || b == 8'h0D;
  endfunction

  function automatic logic is_word(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h30 && b <= 8'h39) || b == ChUnder;
  endfunction

  function automatic logic is_punct(logic [7:0] b);
    return b == ChLParen || b == 8'h29 || b == 8'h7B || b == 8'h7D ||
           b == 8'h5B || b == 8'h5D || b == 8'h2C || b == ChSemi || b == 8'h3A;
  endfunction

  function automatic stt_pkg::record_t mk_rec(stt_pkg::token_kind_e kind,
                                              logic [Pb-1:0] start,
                                              logic [Pb-1:0] len,
                                              logic [LcBits-1:0] line,
                                              logic [LcBits-1:0] col);
    stt_pkg::record_t r;
    r.kind  = kind;
    r.start = 32'(start);
    r.len   = 32'(len);
    r.line  = 32'(line);
    r.col   = 32'(col);
    return r;
  endfunction

  // Record for the open token when something closes it
  function automatic close_t close_tok(logic [2:0] mode, stt_pkg::cfg_t cfg,
                                       logic [Pb-1:0] pos, logic [Pb-1:0] ts,
                                       logic [LcBits-1:0] tl,
                                       logic [LcBits-1:0] tc);
    close_t r;
    r.en  = 1'b0;
    r.rec = mk_rec(stt_pkg::KindSpace, ts, pos - ts, tl, tc);
    unique case (mode)
      ModeSpace: begin
        r.en = cfg.keep_whitespace;
      end
      ModeComment: begin
        r.en       = cfg.keep_comments;
        r.rec.kind = stt_pkg::KindComment;
      end
      ModeSlash: begin
        r.en       = 1'b1;
        r.rec.kind = stt_pkg::KindError;
        r.rec.len  = 32'd1;
      end
      ModeString, ModeEscape: begin
        r.en       = 1'b1;
        r.rec.kind = stt_pkg::KindString;
      end
      ModeWord: begin
        r.en       = 1'b1;
        r.rec.kind = stt_pkg::KindWord;
      end
      default: begin
        r.en = 1'b0;
      end
    endcase
    return r;
  endfunction

  logic [2:0]        mode_q, mode_d;
  logic [Pb-1:0]     pos_q, pos_d;
  logic [Pb-1:0]     tstart_q, tstart_d;
  logic [LcBits-1:0] tline_q, tline_d;
  logic [LcBits-1:0] tcol_q, tcol_d;
  logic [LcBits-1:0] cline_q, cline_d;
  logic [LcBits-1:0] ccol_q, ccol_d;

  logic             accept;
  logic             do_close;
  logic             do_start;
  logic [1:0]       n;
  close_t           cr;
  stt_pkg::bundle_t bnd;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // Next scan state and the records of this item
  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    tstart_d = tstart_q;
    tline_d  = tline_q;
    tcol_d   = tcol_q;
    cline_d  = cline_q;
    ccol_d   = ccol_q;
    do_close = 1'b0;
    do_start = 1'b0;
    n        = 2'd0;
    cr       = '0;
    bnd      = '0;

    if (has_byte_i) begin
      unique case (mode_q)
        ModeSpace: begin
          if (!is_space(byte_value_i)) begin
            do_close = 1'b1;
            do_start = 1'b1;
          end
        end
        ModeSlash: begin
          if (byte_value_i == ChSlash) begin
            mode_d = ModeComment;
          end else begin
            do_close = 1'b1;
            do_start = 1'b1;
          end
        end
        ModeComment: begin
          if (byte_value_i == ChNewline) begin
            do_close = 1'b1;
            do_start = 1'b1;
          end
        end
        ModeString: begin
          if (byte_value_i == ChBslash) begin
            mode_d = ModeEscape;
          end else if (byte_value_i == ChQuote) begin
            // closing quote belongs to the string
            bnd.rec[n] = mk_rec(stt_pkg::KindString, tstart_q,
                                pos_q + Pb'(1) - tstart_q, tline_q, tcol_q);
            n      = n + 2'd1;
            mode_d = ModeIdle;
          end
        end
        ModeEscape: begin
          mode_d = ModeString;
        end
        ModeWord: begin
          if (!is_word(byte_value_i)) begin
            do_close = 1'b1;
            do_start = 1'b1;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase

      if (do_close) begin
        cr = close_tok(mode_q, cfg_i, pos_q, tstart_q, tline_q, tcol_q);
        if (cr.en) begin
          bnd.rec[n] = cr.rec;
          n          = n + 2'd1;
        end
        mode_d = ModeIdle;
      end

      if (do_start) begin
        tstart_d = pos_q;
        tline_d  = cline_q;
        tcol_d   = ccol_q;
        if (is_space(byte_value_i)) begin
          mode_d = ModeSpace;
        end else if (byte_value_i == ChSlash) begin
          mode_d = ModeSlash;
        end else if (byte_value_i == ChQuote) begin
          mode_d = ModeString;
        end else if (is_word(byte_value_i)) begin
          mode_d = ModeWord;
        end else begin
          mode_d     = ModeIdle;
          bnd.rec[n] = mk_rec(is_punct(byte_value_i) ? stt_pkg::KindPunct
                                                     : stt_pkg::KindError,
                              pos_q, Pb'(1), cline_q, ccol_q);
          n          = n + 2'd1;
        end
      end

      // position counters, line and column saturate
      pos_d = pos_q + Pb'(1);
      if (byte_value_i == ChNewline) begin
        if (cline_q != '1) begin
          cline_d = cline_q + LcBits'(1);
        end
        ccol_d = LcBits'(1);
      end else if (ccol_q != '1) begin
        ccol_d = ccol_q + LcBits'(1);
      end
    end

    // End of source: close open token, emit end token, restart
    if (end_of_source_i) begin
      cr = close_tok(mode_d, cfg_i, pos_d, tstart_d, tline_d, tcol_d);
      if (cr.en) begin
        bnd.rec[n] = cr.rec;
        n          = n + 2'd1;
      end
      bnd.rec[n] = mk_rec(stt_pkg::KindEnd, pos_d, '0, cline_d, ccol_d);
      n          = n + 2'd1;
      mode_d     = ModeIdle;
      pos_d      = '0;
      tstart_d   = '0;
      tline_d    = LcBits'(1);
      tcol_d     = LcBits'(1);
      cline_d    = LcBits'(1);
      ccol_d     = LcBits'(1);
    end

    bnd.count = n;
  end

  assign push_o   = accept && (n != 2'd0);
  assign bundle_o = bnd;

  // Scan state, updated on every accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      pos_q    <= '0;
      tstart_q <= '0;
      tline_q  <= LcBits'(1);
      tcol_q   <= LcBits'(1);
      cline_q  <= LcBits'(1);
      ccol_q   <= LcBits'(1);
    end else if (accept) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      tstart_q <= tstart_d;
      tline_q  <= tline_d;
      tcol_q   <= tcol_d;
      cline_q  <= cline_d;
      ccol_q   <= ccol_d;
    end
  end

  // An end of source restarts the scanner at the origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_source_i |=>
      mode_q == ModeIdle && pos_q == '0 && cline_q == LcBits'(1) &&
      ccol_q == LcBits'(1))
    else $error("scanner not restarted after end of source");

endmodule

// ===== hw/rtl/stt_fifo.sv =====
// ----------------------------------------------------------------------------
// stt_fifo
// Record bundle queue between scanner front end and token output back end.
// Registered storage, head readable while not empty.
// ----------------------------------------------------------------------------
module stt_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  stt_pkg::bundle_t data_i,
  input  logic             pop_i,
  output stt_pkg::bundle_t data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  stt_pkg::bundle_t mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign data_o  = mem_q[rptr_q];

  // Pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("record queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("record queue underflow");

endmodule

// ===== hw/rtl/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back
// Token output back end: walks the head bundle's records into the output
// register one per cycle unless stalled, releasing the bundle after its last.
// ----------------------------------------------------------------------------
module stt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stt_pkg::bundle_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output stt_pkg::record_t rec_o,
  output logic             last_o
);

  logic [1:0]       idx_q, idx_d;
  logic             valid_q, valid_d;
  stt_pkg::record_t rec_q;
  logic             last_q;
  logic             load;
  logic             is_last;

  // Output register is free when empty or being taken this cycle
  assign load    = !empty_i && (!valid_q || !out_stall_i);
  assign is_last = (idx_q == head_i.count - 2'd1);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = is_last ? 2'd0 : idx_q + 2'd1;
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Output payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      rec_q  <= head_i.rec[idx_q];
      last_q <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;
  assign last_o      = last_q;

  // Record index stays inside the head bundle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> idx_q < head_i.count)
    else $error("record index beyond head bundle");

endmodule

// ===== hw/rtl/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming tokenizer: source bytes in, token records (kind, offset,
// length, line, column) out, through a record queue.
// ----------------------------------------------------------------------------
// Path: an item's records are queued as one bundle, then loaded into the output register.
// Throughput: one item per cycle while items produce at most one token
//   and the output is not stalled; the output port moves one token per cycle,
//   so an item's tokens leave one after another, buffered by FIFO_DEPTH queued items.
// Reset: scanner at offset 0, line 1, column 1, keep flags cleared,
//   queue and output register empty.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned FIFO_DEPTH    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic        cfg_wdata_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        has_byte_i,
  input  logic        end_of_source_i,
  // token output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_kind_o,
  output logic [31:0] start_offset_o,
  output logic [31:0] token_length_o,
  output logic [31:0] start_line_o,
  output logic [31:0] start_column_o,
  output logic        last_of_run_o
);

  stt_pkg::cfg_t    cfg_q;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  stt_pkg::bundle_t push_data;
  stt_pkg::bundle_t head;
  stt_pkg::record_t rec;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        stt_pkg::CfgKeepWhitespace: cfg_q.keep_whitespace <= cfg_wdata_i;
        stt_pkg::CfgKeepComments:   cfg_q.keep_comments   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  stt_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .byte_value_i    (byte_value_i),
    .has_byte_i      (has_byte_i),
    .end_of_source_i (end_of_source_i),
    .cfg_i           (cfg_q),
    .full_i          (full),
    .push_o          (push),
    .bundle_o        (push_data)
  );

  stt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  stt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rec_o       (rec),
    .last_o      (last_of_run_o)
  );

  assign token_kind_o   = rec.kind;
  assign start_offset_o = rec.start;
  assign token_length_o = rec.len;
  assign start_line_o   = rec.line;
  assign start_column_o = rec.col;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for source_text_tokenizer. Source bytes are fed as
// short directed text and as random token-shaped fragments under several
// keep-flag settings and idle/stall mixes. A behavioral scanner in the bench
// predicts each token record, and every output transfer is checked in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 8;

  // Character codes the scanner reacts to
  localparam logic [7:0] ChNewline    = 8'h0A;
  localparam logic [7:0] ChSlash      = 8'h2F;
  localparam logic [7:0] ChQuote      = 8'h22;
  localparam logic [7:0] ChBackslash  = 8'h5C;
  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChSpace      = 8'h20;

  typedef enum logic [2:0] {
    ScanIdle, ScanSpace, ScanSlash, ScanComment, ScanString, ScanEscape, ScanWord
  } scan_e;

  typedef struct packed {
    stt_pkg::token_kind_e kind;
    logic [31:0]          start;
    logic [31:0]          len;
    logic [31:0]          line;
    logic [31:0]          col;
    logic                 last;
  } token_rec_t;

  // DUT ports
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i     = stt_pkg::CfgKeepWhitespace;
  logic        cfg_wdata_i     = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [7:0]  byte_value_i    = 8'h00;
  logic        has_byte_i      = 1'b0;
  logic        end_of_source_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [2:0]  token_kind_o;
  logic [31:0] start_offset_o;
  logic [31:0] token_length_o;
  logic [31:0] start_line_o;
  logic [31:0] start_column_o;
  logic        last_of_run_o;

  source_text_tokenizer dut (.*);

  // Scanner mirror and keep flags
  scan_e       scan;
  logic [31:0] pos, tok_start, tok_line, tok_col, cur_line, cur_col;
  logic        keep_ws, keep_cm;

  token_rec_t  step_tokens[$];
  token_rec_t  pending_tokens[$];
  token_rec_t  want;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_cycles   = 0;
  int sent_items    = 0;
  int fail_cnt      = 0;
  int cycle_cnt     = 0;

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Token predictor
  // --------------------------------------------------------------------------
  function automatic bit is_space(logic [7:0] b);
    return b == ChSpace || b == 8'h09 || b == ChNewline || b == 8'h0B ||
           b == 8'h0C || b == 8'h0D;
  endfunction

  function automatic bit is_word(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h30 && b <= 8'h39) || b == ChUnderscore;
  endfunction

  function automatic bit is_punct(logic [7:0] b);
    case (b)
      8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h2C, 8'h3B, 8'h3A: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void add_token(stt_pkg::token_kind_e k, logic [31:0] s,
                                    logic [31:0] n, logic [31:0] ln,
                                    logic [31:0] cl);
    token_rec_t r;
    r = '{kind: k, start: s, len: n, line: ln, col: cl, last: 1'b0};
    step_tokens.push_back(r);
  endfunction

  // Emit the open token from its saved start
  function automatic void add_open(stt_pkg::token_kind_e k, logic [31:0] n);
    add_token(k, tok_start, n, tok_line, tok_col);
  endfunction

  function automatic void close_token();
    case (scan)
      ScanSpace:   if (keep_ws) add_open(stt_pkg::KindSpace, pos - tok_start);
      ScanComment: if (keep_cm) add_open(stt_pkg::KindComment, pos - tok_start);
      ScanSlash:   add_open(stt_pkg::KindError, 32'd1);
      ScanString, ScanEscape: add_open(stt_pkg::KindString, pos - tok_start);
      ScanWord:    add_open(stt_pkg::KindWord, pos - tok_start);
      default: ;
    endcase
    scan = ScanIdle;
  endfunction

  function automatic void open_token(logic [7:0] b);
    tok_start = pos;
    tok_line  = cur_line;
    tok_col   = cur_col;
    if (is_space(b)) scan = ScanSpace;
    else if (b == ChSlash) scan = ScanSlash;
    else if (b == ChQuote) scan = ScanString;
    else if (is_word(b)) scan = ScanWord;
    else begin
      scan = ScanIdle;
      add_open(is_punct(b) ? stt_pkg::KindPunct : stt_pkg::KindError, 32'd1);
    end
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    case (scan)
      ScanSpace: if (!is_space(b)) begin
        close_token();
        open_token(b);
      end
      ScanSlash: if (b == ChSlash) scan = ScanComment;
        else begin
          close_token();
          open_token(b);
        end
      ScanComment: if (b == ChNewline) begin
        close_token();
        open_token(b);
      end
      ScanString: if (b == ChBackslash) scan = ScanEscape;
        else if (b == ChQuote) begin
          add_open(stt_pkg::KindString, pos + 32'd1 - tok_start);
          scan = ScanIdle;
        end
      ScanEscape: scan = ScanString;
      ScanWord: if (!is_word(b)) begin
        close_token();
        open_token(b);
      end
      default: open_token(b);
    endcase
    pos = pos + 32'd1;
    // line and column saturate at all ones
    if (b == ChNewline) begin
      if (cur_line != '1) cur_line = cur_line + 32'd1;
      cur_col = 32'd1;
    end else if (cur_col != '1) begin
      cur_col = cur_col + 32'd1;
    end
  endfunction

  function automatic void restart_scan();
    scan      = ScanIdle;
    pos       = '0;
    tok_start = '0;
    tok_line  = 32'd1;
    tok_col   = 32'd1;
    cur_line  = 32'd1;
    cur_col   = 32'd1;
  endfunction

  // Tokens caused by one accepted item, last one flagged
  function automatic void predict_tokens(logic [7:0] b, logic hb, logic eos);
    token_rec_t r;
    step_tokens.delete();
    if (hb) scan_byte(b);
    if (eos) begin
      close_token();
      add_token(stt_pkg::KindEnd, pos, 32'd0, cur_line, cur_col);
      restart_scan();
    end
    while (step_tokens.size() > 0) begin
      r = step_tokens.pop_front();
      r.last = (step_tokens.size() == 0);
      pending_tokens.push_back(r);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output side: stall generation and result check
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tokens.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("ERROR: unexpected token kind=%0d start=%0d len=%0d line=%0d col=%0d",
                   token_kind_o, start_offset_o, token_length_o, start_line_o,
                   start_column_o);
      end else begin
        want = pending_tokens.pop_front();
        if (token_kind_o != want.kind || start_offset_o != want.start ||
            token_length_o != want.len || start_line_o != want.line ||
            start_column_o != want.col || last_of_run_o != want.last) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("ERROR: token mismatch at cycle %0d", cycle_cnt);
            $display("  expected kind=%0d start=%0d len=%0d line=%0d col=%0d last=%0b",
                     want.kind, want.start, want.len, want.line, want.col, want.last);
            $display("  actual   kind=%0d start=%0d len=%0d line=%0d col=%0d last=%0b",
                     token_kind_o, start_offset_o, token_length_o, start_line_o,
                     start_column_o, last_of_run_o);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("** source_text_tokenizer: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // One input transfer; called at a rising edge
  task automatic send_item(input logic [7:0] b, input logic hb, input logic eos);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i      <= 1'b1;
    byte_value_i    <= b;
    has_byte_i      <= hb;
    end_of_source_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    predict_tokens(b, hb, eos);
    if (hb || eos) sent_items++;
  endtask

  task automatic send_text(input string s, input bit end_on_last);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b1, end_on_last && i == s.len() - 1);
  endtask

  // Stop sending and wait until every expected token has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_keep(input logic ws, input logic cm);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= stt_pkg::CfgKeepWhitespace;
    cfg_wdata_i <= ws;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= stt_pkg::CfgKeepComments;
    cfg_wdata_i <= cm;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    keep_ws = ws;
    keep_cm = cm;
  endtask

  function automatic logic [7:0] pick_word_char();
    case ($urandom_range(3))
      0: return 8'h61 + 8'($urandom_range(25));
      1: return 8'h41 + 8'($urandom_range(25));
      2: return 8'h30 + 8'($urandom_range(9));
      default: return ChUnderscore;
    endcase
  endfunction

  function automatic logic [7:0] pick_space_char();
    case ($urandom_range(5))
      0: return ChSpace;
      1: return 8'h09;
      2: return ChNewline;
      3: return 8'h0B;
      4: return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic logic [7:0] pick_punct_char();
    case ($urandom_range(8))
      0: return 8'h28;
      1: return 8'h29;
      2: return 8'h7B;
      3: return 8'h7D;
      4: return 8'h5B;
      5: return 8'h5D;
      6: return 8'h2C;
      7: return 8'h3B;
      default: return 8'h3A;
    endcase
  endfunction

  // Random token-shaped fragments with some noise, until n more items are sent
  task automatic run_random(input int n);
    int          target;
    int unsigned sel;
    logic [7:0]  c;
    target = sent_items + n;
    while (sent_items < target) begin
      sel = $urandom_range(99);
      if (sel < 20) begin
        repeat ($urandom_range(1, 6)) send_item(pick_word_char(), 1'b1, 1'b0);
      end else if (sel < 32) begin
        repeat ($urandom_range(1, 4)) send_item(pick_space_char(), 1'b1, 1'b0);
      end else if (sel < 44) begin
        // quoted string, sometimes left open
        send_item(ChQuote, 1'b1, 1'b0);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(5) == 0) begin
            send_item(ChBackslash, 1'b1, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, 1'b0);
          end else begin
            do c = 8'($urandom_range(255)); while (c == ChQuote || c == ChBackslash);
            send_item(c, 1'b1, 1'b0);
          end
        end
        if ($urandom_range(9) != 0) send_item(ChQuote, 1'b1, 1'b0);
      end else if (sel < 54) begin
        // line comment
        send_item(ChSlash, 1'b1, 1'b0);
        send_item(ChSlash, 1'b1, 1'b0);
        repeat ($urandom_range(0, 5)) begin
          do c = 8'($urandom_range(255)); while (c == ChNewline);
          send_item(c, 1'b1, 1'b0);
        end
        send_item(ChNewline, 1'b1, 1'b0);
      end else if (sel < 66) begin
        send_item(pick_punct_char(), 1'b1, 1'b0);
      end else if (sel < 72) begin
        send_item(ChSlash, 1'b1, 1'b0);
      end else if (sel < 80) begin
        send_item(8'($urandom_range(255)), 1'b1, 1'b0);
      end else if (sel < 84) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      end else if (sel < 90) begin
        send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      end else begin
        send_item(ChNewline, 1'b1, 1'b0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Every token kind, lone slash, escaped quote, open escape at end, empty end
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    set_keep(1'b1, 1'b1);
    send_text("z_A9 (/x//c\n\"q\\\"\";", 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_text("\"a\\", 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h7B, 1'b1, 1'b1);
  endtask

  task automatic test_no_idling();
    wait_idle();
    set_keep(1'b0, 1'b0);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(90);
  endtask

  task automatic test_sender_gaps();
    wait_idle();
    set_keep(1'b1, 1'b1);
    send_idle_pct = 77;
    stall_pct     = 0;
    run_random(90);
  endtask

  task automatic test_receiver_stalls();
    wait_idle();
    set_keep(1'b1, 1'b0);
    send_idle_pct = 0;
    stall_pct     = 77;
    run_random(90);
  endtask

  task automatic test_both_idle();
    wait_idle();
    set_keep(1'b0, 1'b1);
    send_idle_pct = 6;
    stall_pct     = 6;
    run_random(90);
  endtask

  // Long output hold fills the queue; then a full drain before resuming
  task automatic test_backpressure();
    wait_idle();
    set_keep(1'b1, 1'b1);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 80;
    repeat (40) send_item(pick_punct_char(), 1'b1, 1'b0);
    wait_idle();
    run_random(20);
  endtask

  initial begin
    keep_ws = 1'b0;
    keep_cm = 1'b0;
    restart_scan();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_no_idling();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();
    wait_idle();

    if (fail_cnt == 0) begin
      $display("** source_text_tokenizer: PASSED **");
    end else begin
      $display("** source_text_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule
